/* hdl/rrts_pkg.sv */
// types and constants for the round-robin thread scheduler
package rrts_pkg;

    localparam logic [2:0] REQ_SWITCH = 3'd0;
    localparam logic [2:0] REQ_CREATE = 3'd1;
    localparam logic [2:0] REQ_START  = 3'd2;
    localparam logic [2:0] REQ_EXIT   = 3'd3;
    localparam logic [2:0] REQ_SET    = 3'd4;

    localparam logic [2:0] ST_READY   = 3'd0;
    localparam logic [2:0] ST_RUNNING = 3'd1;
    localparam logic [2:0] ST_BLOCKED = 3'd2;
    localparam logic [2:0] ST_ZOMBIE  = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NO_READY = 2'd2;
    localparam logic [1:0] STAT_IGNORED  = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] context_value;
        logic [31:0] stack_top_in;
        logic [3:0]  target_slot;
        logic [1:0]  new_state;
    } rrts_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chosen_slot;
        logic [31:0] chosen_number;
        logic [31:0] next_context;
        logic [31:0] next_stack_top;
    } rrts_out_t;

endpackage

/* hdl/round_robin_thread_scheduler.sv */
// round-robin thread scheduler: slot ring, request sequencer and ring walk
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------
//  in      | input     | in_valid/in_ready | rrts_in_t
//  out     | output    | out_valid/out_ready | rrts_out_t
//
// one request at a time; a switch walks the ring one slot per cycle through a
// single shared slot-state compare and link-update step in the walk state; a
// create scans for a free slot one slot per cycle in the scan state; other
// requests pass through the decode and done states before the output handshake.
// reset marks every slot empty; links and payload stores need no reset.
// a stalled result holds in the output register; in_ready stays low until taken.
module round_robin_thread_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_THREADS   = 16,
    parameter int CONTEXT_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rrts_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output rrts_out_t out_data
);

    localparam int SW = $clog2(MAX_THREADS);
    localparam int CW = (SW > 1) ? SW : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // slot tables
    logic [2:0]               state_reg [MAX_THREADS];
    logic [CW-1:0]            nlink_mem [MAX_THREADS];
    logic [CW-1:0]            plink_mem [MAX_THREADS];
    logic [CONTEXT_WIDTH-1:0] ctx_mem   [MAX_THREADS];
    logic [CONTEXT_WIDTH-1:0] top_mem   [MAX_THREADS];
    logic [31:0]              num_mem   [MAX_THREADS];

    logic [2:0]   fsm_reg;
    logic [CW-1:0] cur_reg;
    logic          empty_reg;
    logic [31:0]   counter_reg;
    rrts_in_t      req_reg;
    logic [CW-1:0] pos_reg;      // walk position or scan index
    logic [CW:0]   steps_reg;    // walk/scan step count
    logic          found_reg;
    rrts_out_t     out_reg;
    logic [1:0]    stat_reg;
    logic [CW-1:0] res_slot_reg;
    logic          zero_fields_reg;
    logic [3:0]    res_raw_slot_reg;

    function automatic logic [31:0] ext(input logic [CONTEXT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    logic [CW-1:0] tgt_idx;
    logic          tgt_ok;
    assign tgt_idx = CW'(req_reg.target_slot);
    assign tgt_ok  = ({28'd0, req_reg.target_slot} < 32'(MAX_THREADS)) &&
                     (state_reg[tgt_idx] != ST_EMPTY);

    logic [2:0]    pst;
    logic [CW-1:0] pn, pp;
    assign pst = state_reg[pos_reg];
    assign pn  = nlink_mem[pos_reg];
    assign pp  = plink_mem[pos_reg];

    assign in_ready  = (fsm_reg == S_IDLE);
    assign out_valid = (fsm_reg == S_OUT);
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fsm_reg     <= S_IDLE;
            cur_reg     <= '0;
            empty_reg   <= 1'b1;
            counter_reg <= '0;
            for (int i = 0; i < MAX_THREADS; i++) begin
                state_reg[i] <= ST_EMPTY;
            end
        end else begin
            unique case (fsm_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        req_reg <= in_data;
                        fsm_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    unique case (req_reg.req_type)
                        REQ_SWITCH: begin
                            res_slot_reg     <= cur_reg;
                            res_raw_slot_reg <= 4'(cur_reg);
                            if (empty_reg) begin
                                stat_reg        <= STAT_NO_READY;
                                zero_fields_reg <= 1'b1;
                                fsm_reg         <= S_DONE;
                            end else begin
                                stat_reg         <= STAT_OK;
                                zero_fields_reg  <= 1'b0;
                                ctx_mem[cur_reg] <=
                                    CONTEXT_WIDTH'(req_reg.context_value);
                                if (state_reg[cur_reg] == ST_RUNNING) begin
                                    state_reg[cur_reg] <= ST_READY;
                                end
                                pos_reg   <= nlink_mem[cur_reg];
                                steps_reg <= '0;
                                found_reg <= 1'b0;
                                fsm_reg   <= S_WALK;
                            end
                        end
                        REQ_CREATE: begin
                            stat_reg         <= STAT_OK;
                            zero_fields_reg  <= 1'b0;
                            res_slot_reg     <= cur_reg;
                            res_raw_slot_reg <= 4'(cur_reg);
                            pos_reg          <= '0;
                            steps_reg        <= '0;
                            fsm_reg          <= S_SCAN;
                        end
                        REQ_START, REQ_SET: begin
                            res_raw_slot_reg <= req_reg.target_slot;
                            res_slot_reg     <= tgt_idx;
                            fsm_reg          <= S_DONE;
                            if (!tgt_ok) begin
                                stat_reg        <= STAT_IGNORED;
                                zero_fields_reg <= 1'b1;
                            end else begin
                                stat_reg        <= STAT_OK;
                                zero_fields_reg <= 1'b0;
                                if (req_reg.req_type == REQ_SET) begin
                                    state_reg[tgt_idx] <= {1'b0, req_reg.new_state};
                                end else if (state_reg[tgt_idx] == ST_BLOCKED) begin
                                    state_reg[tgt_idx] <= ST_READY;
                                end
                            end
                        end
                        REQ_EXIT: begin
                            res_slot_reg     <= cur_reg;
                            res_raw_slot_reg <= 4'(cur_reg);
                            fsm_reg          <= S_DONE;
                            if (empty_reg) begin
                                stat_reg        <= STAT_IGNORED;
                                zero_fields_reg <= 1'b1;
                            end else begin
                                stat_reg           <= STAT_OK;
                                zero_fields_reg    <= 1'b0;
                                state_reg[cur_reg] <= ST_ZOMBIE;
                            end
                        end
                        default: begin
                            stat_reg         <= STAT_OK;
                            res_slot_reg     <= cur_reg;
                            res_raw_slot_reg <= '0;
                            zero_fields_reg  <= 1'b1;
                            fsm_reg          <= S_DONE;
                        end
                    endcase
                end
                S_WALK: begin
                    // one ring slot per cycle
                    if (found_reg || empty_reg ||
                        steps_reg == (CW+1)'(MAX_THREADS)) begin
                        if (found_reg) begin
                            cur_reg          <= pos_reg;
                            res_slot_reg     <= pos_reg;
                            res_raw_slot_reg <= 4'(pos_reg);
                        end else begin
                            stat_reg <= STAT_NO_READY;
                            if (!empty_reg && state_reg[cur_reg] == ST_EMPTY) begin
                                cur_reg          <= pos_reg;
                                res_slot_reg     <= pos_reg;
                                res_raw_slot_reg <= 4'(pos_reg);
                            end
                            zero_fields_reg <= empty_reg;
                        end
                        fsm_reg <= S_DONE;
                    end else begin
                        steps_reg <= steps_reg + 1'b1;
                        if (pst == ST_ZOMBIE || pst == ST_EMPTY) begin
                            state_reg[pos_reg] <= ST_EMPTY;
                            if (pn == pos_reg) begin
                                empty_reg <= 1'b1;
                            end else begin
                                nlink_mem[pp] <= pn;
                                plink_mem[pn] <= pp;
                                pos_reg       <= pn;
                            end
                        end else if (pst == ST_READY) begin
                            state_reg[pos_reg] <= ST_RUNNING;
                            found_reg          <= 1'b1;
                        end else begin
                            pos_reg <= pn;
                        end
                    end
                end
                S_SCAN: begin
                    if (steps_reg == (CW+1)'(MAX_THREADS)) begin
                        stat_reg         <= STAT_FULL;
                        zero_fields_reg  <= 1'b1;
                        res_raw_slot_reg <= '0;
                        fsm_reg          <= S_DONE;
                    end else if (pst == ST_EMPTY) begin
                        state_reg[pos_reg] <= ST_BLOCKED;
                        ctx_mem[pos_reg]   <= CONTEXT_WIDTH'(req_reg.context_value);
                        top_mem[pos_reg]   <= CONTEXT_WIDTH'(req_reg.stack_top_in);
                        num_mem[pos_reg]   <= counter_reg;
                        counter_reg        <= counter_reg + 32'd1;
                        res_slot_reg       <= pos_reg;
                        res_raw_slot_reg   <= 4'(pos_reg);
                        if (empty_reg) begin
                            nlink_mem[pos_reg] <= pos_reg;
                            plink_mem[pos_reg] <= pos_reg;
                            cur_reg            <= pos_reg;
                            empty_reg          <= 1'b0;
                        end else begin
                            nlink_mem[pos_reg]            <= nlink_mem[cur_reg];
                            plink_mem[pos_reg]            <= cur_reg;
                            plink_mem[nlink_mem[cur_reg]] <= pos_reg;
                            nlink_mem[cur_reg]            <= pos_reg;
                        end
                        fsm_reg <= S_DONE;
                    end else begin
                        pos_reg   <= pos_reg + 1'b1;
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                S_DONE: begin
                    out_reg.status      <= stat_reg;
                    out_reg.chosen_slot <= res_raw_slot_reg;
                    if (zero_fields_reg) begin
                        out_reg.chosen_number  <= '0;
                        out_reg.next_stack_top <= '0;
                    end else begin
                        out_reg.chosen_number  <= num_mem[res_slot_reg];
                        out_reg.next_stack_top <= ext(top_mem[res_slot_reg]);
                    end
                    // nothing ready: hand back the caller's own context
                    if (stat_reg == STAT_NO_READY) begin
                        out_reg.next_context <= req_reg.context_value;
                    end else if (zero_fields_reg) begin
                        out_reg.next_context <= '0;
                    end else begin
                        out_reg.next_context <= ext(ctx_mem[res_slot_reg]);
                    end
                    fsm_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) begin
                        fsm_reg <= S_IDLE;
                    end
                end
                default: fsm_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("ready while result pending");
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (fsm_reg == S_DECODE))
        else $error("accepted request not decoded");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_reg)))
        else $error("stalled result changed");

endmodule
